// ===== design/ula_pkg.sv =====
// ----------------------------------------------------------------------------
// ula_pkg
// Shared constants, opcodes, command/status types and the power-up palette
// for the ULA line renderer.
// ----------------------------------------------------------------------------
package ula_pkg;

    localparam int ULA_MEM_DEPTH    = 8192;
    localparam int ULA_FLASH_FRAMES = 16;
    localparam int PALETTE_ENTRIES  = 64;
    localparam int PAL_AW           = $clog2(PALETTE_ENTRIES);
    localparam int CELLS            = 32;
    localparam int STEPS            = 2 * CELLS;

    localparam logic [12:0] ATTR_BASE = 13'd6144;

    // transaction opcodes
    localparam logic [2:0] OP_SCREEN = 3'd0;
    localparam logic [2:0] OP_BORDER = 3'd1;
    localparam logic [2:0] OP_SELECT = 3'd2;
    localparam logic [2:0] OP_DATA   = 3'd3;
    localparam logic [2:0] OP_RENDER = 3'd4;
    localparam logic [2:0] OP_TICK   = 3'd5;

    localparam logic [1:0] GROUP_MODE = 2'd1;

    typedef struct packed {
        logic       accept;     // latch the transaction fields
        logic       exec;       // carry out a bus event
        logic       border_rd;  // palette lookup for a border write
        logic       clear;      // one step of the screen clearing pass
        logic       rd_issue;   // screen read for rendering
        logic       rd_bmp;     // 0 attribute, 1 bitmap
        logic [4:0] column;
    } ula_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ula_status_t;

    localparam logic [7:0] PAL_DEFAULT [PALETTE_ENTRIES] = '{
        8'h00, 8'h02, 8'h18, 8'h1b, 8'hc0, 8'hc3, 8'hd8, 8'hdb,
        8'h00, 8'h02, 8'h18, 8'h1b, 8'hc0, 8'hc3, 8'hd8, 8'hdb,
        8'h00, 8'h03, 8'h1c, 8'h1f, 8'he0, 8'he3, 8'hfc, 8'hff,
        8'h00, 8'h03, 8'h1c, 8'h1f, 8'he0, 8'he3, 8'hfc, 8'hff,
        8'hdb, 8'hd8, 8'hc3, 8'hc0, 8'h1b, 8'h18, 8'h02, 8'h00,
        8'hdb, 8'hd8, 8'hc3, 8'hc0, 8'h1b, 8'h18, 8'h02, 8'h00,
        8'hff, 8'hfc, 8'he3, 8'he0, 8'h1f, 8'h1c, 8'h03, 8'h00,
        8'hff, 8'hfc, 8'he3, 8'he0, 8'h1f, 8'h1c, 8'h03, 8'h00
    };

endpackage

// ===== design/ula_ctrl.sv =====
// ----------------------------------------------------------------------------
// ula_ctrl
// Sequencer: clearing pass after reset, bus event execution and the
// 64-step read schedule of a line render.
// ----------------------------------------------------------------------------
module ula_ctrl
    import ula_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  command,
    input  ula_status_t status,
    output ula_cmd_t    cmd,
    output logic        busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_BREAD  = 3'd3;
    localparam logic [2:0] S_RENDER = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;

    localparam int SW = $clog2(STEPS);

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic          accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.accept    = accept;
        cmd.rd_bmp    = step_reg[0];
        cmd.column    = step_reg[SW-1:1];
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    step_next = '0;
                    if (command == OP_RENDER)
                    begin
                        state_next = S_RENDER;
                    end
                    else if (command == OP_BORDER)
                    begin
                        state_next = S_BREAD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_BREAD:
            begin
                cmd.border_rd = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            S_RENDER:
            begin
                cmd.rd_issue = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == SW'(STEPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== design/ula_datapath.sv =====
// ----------------------------------------------------------------------------
// ula_datapath
// Screen store, palette store, ULA registers, flash timing and the cell
// pipeline: attribute read, bitmap read and palette lookup, then compose.
// ----------------------------------------------------------------------------
module ula_datapath
    import ula_pkg::*;
#(
    parameter int MEM_DEPTH    = ULA_MEM_DEPTH,
    parameter int FLASH_FRAMES = ULA_FLASH_FRAMES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ula_cmd_t    cmd,
    output ula_status_t status,
    input  logic [2:0]  command,
    input  logic [12:0] bus_address,
    input  logic [7:0]  bus_data,
    input  logic [7:0]  row_number,
    output logic        strobe,
    output logic [63:0] cell_pixels,
    output logic [4:0]  cell_index,
    output logic        last_cell,
    output logic [7:0]  border_out,
    output logic        extended_mode
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int FCW = (FLASH_FRAMES > 1) ? $clog2(FLASH_FRAMES) : 1;

    // transaction fields
    logic [2:0]  op_reg;
    logic [12:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  row_reg;

    // ULA registers
    logic [7:0]     border_reg;
    logic [7:0]     select_reg;
    logic           mode_reg;
    logic [FCW-1:0] frame_reg;
    logic           phase_reg;
    logic [FCW:0]   frame_inc;

    // stores
    logic [7:0] scr_mem [MEM_DEPTH];
    logic [7:0] pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] pal_valid_reg;

    logic [AW-1:0] clear_addr_reg;
    logic          scr_we;
    logic [AW-1:0] scr_wa;
    logic [7:0]    scr_wd;
    logic [12:0]   scr_ra;
    logic [7:0]    scr_raw_reg;
    logic          scr_in_range_reg;
    logic [7:0]    scr_rd;
    logic          pal_we;

    logic [PAL_AW-1:0] pal_a_addr, pal_b_addr;
    logic [7:0]        pal_a_reg, pal_b_reg;

    // cell pipeline
    logic        p1_reg, p2_reg;
    logic [4:0]  idx_reg;
    logic [7:0]  attr_reg;
    logic [7:0]  ink, paper;
    logic [63:0] pixels;

    logic        strobe_reg;
    logic [63:0] pixels_reg;
    logic [4:0]  index_reg;
    logic        last_reg;
    logic [7:0]  border_q_reg;
    logic        mode_q_reg;

    assign status.clear_last = (clear_addr_reg == AW'(MEM_DEPTH - 1));

    // screen read address: bitmap is {y1,line,y2,col}, attribute 6144+{y1,y2,col}
    always_comb
    begin
        if (cmd.rd_bmp)
        begin
            scr_ra = {row_reg[7:6], row_reg[2:0], row_reg[5:3], cmd.column};
        end
        else
        begin
            scr_ra = ATTR_BASE + {3'b000, row_reg[7:6], row_reg[5:3], cmd.column};
        end
    end

    always_comb
    begin
        scr_we = 1'b0;
        scr_wa = clear_addr_reg;
        scr_wd = '0;
        if (cmd.clear)
        begin
            scr_we = 1'b1;
        end
        else if (cmd.exec && op_reg == OP_SCREEN && 32'(addr_reg) < MEM_DEPTH)
        begin
            scr_we = 1'b1;
            scr_wa = AW'(addr_reg);
            scr_wd = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scr_mem[scr_wa] <= scr_wd;
        end
        scr_raw_reg      <= scr_mem[AW'(scr_ra)];
        scr_in_range_reg <= (32'(scr_ra) < MEM_DEPTH);
    end

    assign scr_rd = scr_in_range_reg ? scr_raw_reg : 8'h00;

    // palette: port A ink or border lookup, port B paper
    assign pal_a_addr = cmd.border_rd ? {3'b001, data_reg[2:0]}
                                      : {scr_rd[7:6], 1'b0, scr_rd[2:0]};
    assign pal_b_addr = {scr_rd[7:6], 1'b1, scr_rd[5:3]};
    assign pal_we     = cmd.exec && op_reg == OP_DATA && select_reg[7:6] != GROUP_MODE;

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[select_reg[PAL_AW-1:0]] <= data_reg;
        end
        pal_a_reg <= pal_valid_reg[pal_a_addr] ? pal_mem[pal_a_addr] : PAL_DEFAULT[pal_a_addr];
        pal_b_reg <= pal_valid_reg[pal_b_addr] ? pal_mem[pal_b_addr] : PAL_DEFAULT[pal_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= command;
            addr_reg <= bus_address;
            data_reg <= bus_data;
            row_reg  <= row_number;
        end
        if (cmd.rd_issue && cmd.rd_bmp)
        begin
            idx_reg <= cmd.column;
        end
        if (p1_reg)
        begin
            attr_reg <= scr_rd;
        end
        if (p2_reg)
        begin
            pixels_reg   <= pixels;
            index_reg    <= idx_reg;
            last_reg     <= (idx_reg == 5'(CELLS - 1));
            border_q_reg <= border_reg;
            mode_q_reg   <= mode_reg;
        end
    end

    assign frame_inc = {1'b0, frame_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg     <= '0;
            select_reg     <= '0;
            mode_reg       <= 1'b0;
            frame_reg      <= '0;
            phase_reg      <= 1'b0;
            pal_valid_reg  <= '0;
            clear_addr_reg <= '0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            p1_reg     <= cmd.rd_issue && !cmd.rd_bmp;
            p2_reg     <= cmd.rd_issue && cmd.rd_bmp;
            strobe_reg <= p2_reg;
            if (cmd.clear && !status.clear_last)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (pal_we)
            begin
                pal_valid_reg[select_reg[PAL_AW-1:0]] <= 1'b1;
            end
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_BORDER:
                    begin
                        border_reg <= mode_reg ? pal_a_reg : {5'b00000, data_reg[2:0]};
                    end
                    OP_SELECT:
                    begin
                        select_reg <= data_reg;
                    end
                    OP_DATA:
                    begin
                        if (select_reg[7:6] == GROUP_MODE)
                        begin
                            if (data_reg == 8'd1)
                            begin
                                mode_reg <= 1'b1;
                            end
                            else if (data_reg == 8'd0)
                            begin
                                mode_reg <= 1'b0;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        if (frame_inc >= (FCW+1)'(FLASH_FRAMES))
                        begin
                            frame_reg <= '0;
                            phase_reg <= ~phase_reg;
                        end
                        else
                        begin
                            frame_reg <= frame_inc[FCW-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // compose: attribute in attr_reg, bitmap on scr_rd, palette on port regs
    always_comb
    begin
        if (mode_reg)
        begin
            ink   = pal_a_reg;
            paper = pal_b_reg;
        end
        else if (attr_reg[7] && !phase_reg)
        begin
            ink   = {4'b0000, attr_reg[6], attr_reg[5:3]};
            paper = {4'b0000, attr_reg[6], attr_reg[2:0]};
        end
        else
        begin
            ink   = {4'b0000, attr_reg[6], attr_reg[2:0]};
            paper = {4'b0000, attr_reg[6], attr_reg[5:3]};
        end
        for (int k = 0; k < 8; k++)
        begin
            pixels[8*k +: 8] = scr_rd[7-k] ? ink : paper;
        end
    end

    assign strobe        = strobe_reg;
    assign cell_pixels   = pixels_reg;
    assign cell_index    = index_reg;
    assign last_cell     = last_reg;
    assign border_out    = border_q_reg;
    assign extended_mode = mode_q_reg;

endmodule

// ===== design/ula_video_line_renderer.sv =====
// ----------------------------------------------------------------------------
// ula_video_line_renderer
// ULA-style line renderer with the ULAplus palette extension.
//
//   channel   handshake           payload
//   request   start & !busy       command, bus_address, bus_data, row_number
//   result    strobe (1 cycle)    cell_pixels, cell_index, last_cell,
//                                 border_out, extended_mode
//
// Render: each cell takes an attribute read and then a bitmap read through the
// single read port of the screen store, and busy stays high while the line is
// read. A border write passes through a palette lookup state before it
// executes; other bus events execute directly.
// After reset the screen store is cleared, one byte a cycle, with busy high
// until every byte is written. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module ula_video_line_renderer
    import ula_pkg::*;
#(
    parameter int MEM_DEPTH    = ULA_MEM_DEPTH,
    parameter int FLASH_FRAMES = ULA_FLASH_FRAMES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [12:0] bus_address,
    input  logic [7:0]  bus_data,
    input  logic [7:0]  row_number,
    output logic        strobe,
    output logic [63:0] cell_pixels,
    output logic [4:0]  cell_index,
    output logic        last_cell,
    output logic [7:0]  border_out,
    output logic        extended_mode
);

    ula_cmd_t    cmd;
    ula_status_t status;

    ula_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    ula_datapath #(
        .MEM_DEPTH    (MEM_DEPTH),
        .FLASH_FRAMES (FLASH_FRAMES)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .bus_address   (bus_address),
        .bus_data      (bus_data),
        .row_number    (row_number),
        .strobe        (strobe),
        .cell_pixels   (cell_pixels),
        .cell_index    (cell_index),
        .last_cell     (last_cell),
        .border_out    (border_out),
        .extended_mode (extended_mode)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ULA line renderer. A short list of directed bus
// events and line renders is followed by random traffic. Each cell that comes
// out is compared with a shadow copy of the screen store, the palette, the
// border and mode registers and the flash timing.
// ----------------------------------------------------------------------------
module tb_top;
    import ula_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [7:0] MODE_OFF   = 8'd0;
    localparam logic [7:0] MODE_ON    = 8'd1;

    localparam int MAX_GAP        = 6;
    localparam int TOTAL_ITEMS    = 360;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int MAX_REPORTS    = 100;
    localparam int DIRECTED_ROWS  = 26;

    typedef struct packed {
        logic [63:0] pixels;
        logic [4:0]  column;
        logic        last;
        logic [7:0]  border;
        logic        mode;
    } line_cell_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [7:0]  row;
        bit          typed;
        logic [63:0] pixels;
        logic [7:0]  border;
        bit          mode;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [12:0] bus_address;
    logic [7:0]  bus_data;
    logic [7:0]  row_number;
    logic        strobe;
    logic [63:0] cell_pixels;
    logic [4:0]  cell_index;
    logic        last_cell;
    logic [7:0]  border_out;
    logic        extended_mode;

    // shadow copy of the renderer state
    logic [7:0] shadow_screen [ULA_MEM_DEPTH];
    logic [7:0] shadow_palette [PALETTE_ENTRIES];
    logic [7:0] shadow_border;
    logic [7:0] shadow_select;
    logic       shadow_mode;
    int         shadow_frames;
    logic       shadow_flash;

    line_cell_t    cells_due [$];
    line_cell_t    due_cell;
    directed_row_t directed_rows [DIRECTED_ROWS];
    int            mismatch_count;
    int            items_sent;
    int            calm_items;
    int            idle_cycles;

    ula_video_line_renderer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .bus_address   (bus_address),
        .bus_data      (bus_data),
        .row_number    (row_number),
        .strobe        (strobe),
        .cell_pixels   (cell_pixels),
        .cell_index    (cell_index),
        .last_cell     (last_cell),
        .border_out    (border_out),
        .extended_mode (extended_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] read_screen(logic [12:0] addr);
        return (int'(addr) < ULA_MEM_DEPTH) ? shadow_screen[addr] : 8'h00;
    endfunction

    function automatic void render_line(logic [7:0] row);
        logic [12:0] bmp_base;
        logic [12:0] att_base;
        logic [7:0]  attr;
        logic [7:0]  bits;
        logic [7:0]  ink;
        logic [7:0]  paper;
        line_cell_t  cell_out;
        bmp_base = {row[7:6], row[2:0], row[5:3], 5'd0};
        att_base = ATTR_BASE + {3'b000, row[7:6], row[5:3], 5'd0};
        for (int col = 0; col < CELLS; col++)
        begin
            attr = read_screen(att_base + 13'(col));
            bits = read_screen(bmp_base + 13'(col));
            if (shadow_mode)
            begin
                ink   = shadow_palette[{attr[7], attr[6], 1'b0, attr[2:0]}];
                paper = shadow_palette[{attr[7], attr[6], 1'b1, attr[5:3]}];
            end
            else if (attr[7] && !shadow_flash)
            begin
                ink   = {4'd0, attr[6], attr[5:3]};
                paper = {4'd0, attr[6], attr[2:0]};
            end
            else
            begin
                ink   = {4'd0, attr[6], attr[2:0]};
                paper = {4'd0, attr[6], attr[5:3]};
            end
            for (int k = 0; k < 8; k++)
                cell_out.pixels[8*k +: 8] = bits[7-k] ? ink : paper;
            cell_out.column = 5'(col);
            cell_out.last   = (col == CELLS - 1);
            cell_out.border = shadow_border;
            cell_out.mode   = shadow_mode;
            cells_due.push_back(cell_out);
        end
    endfunction

    function automatic void apply_transaction(logic [2:0] cmd, logic [12:0] addr,
                                              logic [7:0] data, logic [7:0] row);
        case (cmd)
            OP_SCREEN:
                if (int'(addr) < ULA_MEM_DEPTH)
                    shadow_screen[addr] = data;
            OP_BORDER:
                shadow_border = shadow_mode ? shadow_palette[{3'b001, data[2:0]}]
                                            : {5'd0, data[2:0]};
            OP_SELECT:
                shadow_select = data;
            OP_DATA:
                if (shadow_select[7:6] == GROUP_MODE)
                begin
                    if (data == MODE_ON)
                        shadow_mode = 1'b1;
                    else if (data == MODE_OFF)
                        shadow_mode = 1'b0;
                end
                else
                    shadow_palette[shadow_select[5:0]] = data;
            OP_RENDER:
                render_line(row);
            OP_TICK:
            begin
                shadow_frames++;
                if (shadow_frames >= ULA_FLASH_FRAMES)
                begin
                    shadow_frames = 0;
                    shadow_flash  = ~shadow_flash;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch %s: got %h, want %h (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    // Called at a rising edge; returns at the edge on which the transaction
    // is taken. start is left high so that a back-to-back item needs no toggle.
    task automatic send_transaction(input logic [2:0] cmd, input logic [12:0] addr,
                                    input logic [7:0] data, input logic [7:0] row,
                                    input bit typed = 1'b0,
                                    input logic [63:0] typed_pixels = '0,
                                    input logic [7:0] typed_border = '0,
                                    input bit typed_mode = 1'b0);
        int         gap;
        line_cell_t cell_out;
        if (calm_items > 0)
        begin
            gap = 0;
            calm_items--;
        end
        else
        begin
            if ($urandom_range(0, 15) == 0)
                calm_items = $urandom_range(8, 24);
            gap = $urandom_range(0, MAX_GAP);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        bus_address <= addr;
        bus_data    <= data;
        row_number  <= row;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (typed && cmd == OP_RENDER)
        begin
            for (int col = 0; col < CELLS; col++)
            begin
                cell_out = '{typed_pixels, 5'(col), col == CELLS - 1,
                             typed_border, typed_mode};
                cells_due.push_back(cell_out);
            end
        end
        else
            apply_transaction(cmd, addr, data, row);
        if (cmd <= OP_TICK)
            items_sent++;
    endtask

    // result checker: the receiver cannot stall, so every strobe is consumed
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (cells_due.size() == 0)
                report_mismatch("cell with nothing due", cell_pixels, '0);
            else
            begin
                due_cell = cells_due.pop_front();
                if (cell_pixels !== due_cell.pixels)
                    report_mismatch("cell_pixels", cell_pixels, due_cell.pixels);
                if (cell_index !== due_cell.column)
                    report_mismatch("cell_index", 64'(cell_index), 64'(due_cell.column));
                if (last_cell !== due_cell.last)
                    report_mismatch("last_cell", 64'(last_cell), 64'(due_cell.last));
                if (border_out !== due_cell.border)
                    report_mismatch("border_out", 64'(border_out), 64'(due_cell.border));
                if (extended_mode !== due_cell.mode)
                    report_mismatch("extended_mode", 64'(extended_mode),
                                    64'(due_cell.mode));
            end
        end
    end

    // watchdog: cycles with neither a request taken nor a cell delivered
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] row_pick;
        logic [4:0] col;
        int         pick;

        rst_n          = 1'b0;
        start          = 1'b0;
        command        = OP_SCREEN;
        bus_address    = '0;
        bus_data       = '0;
        row_number     = '0;
        mismatch_count = 0;
        items_sent     = 0;
        calm_items     = 0;
        idle_cycles    = 0;

        for (int i = 0; i < ULA_MEM_DEPTH; i++)
            shadow_screen[i] = 8'h00;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            shadow_palette[i] = PAL_DEFAULT[i];
        shadow_border = 8'h00;
        shadow_select = 8'h00;
        shadow_mode   = 1'b0;
        shadow_frames = 0;
        shadow_flash  = 1'b0;

        directed_rows = '{
            // blank store after reset: everything black, border 0
            '{OP_RENDER, 13'd0,    8'h00, 8'd0,   1'b1, 64'h0, 8'h00, 1'b0},
            '{OP_SCREEN, 13'd0,    8'hff, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            // flashing bright attribute, swapped while the flash phase is even
            '{OP_SCREEN, 13'd6144, 8'hc7, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SCREEN, 13'd8191, 8'h80, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SCREEN, 13'd7167, 8'h3f, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_BORDER, 13'd0,    8'hff, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            // untouched third of the screen, border now 7
            '{OP_RENDER, 13'd0,    8'h00, 8'd128, 1'b1, 64'h0, 8'h07, 1'b0},
            '{OP_RENDER, 13'd0,    8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_RENDER, 13'd0,    8'h00, 8'd191, 1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_RENDER, 13'd0,    8'h00, 8'd255, 1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SPARE_A, 13'h1fff, 8'hff, 8'hff, 1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SPARE_B, 13'd0,   8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SELECT, 13'd0,    8'h40, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            // mode value neither on nor off: no effect
            '{OP_DATA,   13'd0,    8'h02, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_RENDER, 13'd0,    8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_DATA,   13'd0,    MODE_ON, 8'd0, 1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_BORDER, 13'd0,    8'h05, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_RENDER, 13'd0,    8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SELECT, 13'd0,    8'h3f, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_DATA,   13'd0,    8'ha5, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SELECT, 13'd0,    8'hff, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_DATA,   13'd0,    8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_SELECT, 13'd0,    8'h40, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_DATA,   13'd0,    MODE_OFF, 8'd0, 1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_TICK,   13'd0,    8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0},
            '{OP_RENDER, 13'd0,    8'h00, 8'd0,   1'b0, 64'h0, 8'h00, 1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_transaction(directed_rows[i].cmd, directed_rows[i].addr,
                             directed_rows[i].data, directed_rows[i].row,
                             directed_rows[i].typed, directed_rows[i].pixels,
                             directed_rows[i].border, directed_rows[i].mode);

        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // poke a few bytes of one line, then draw it
                row_pick = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(192, 255))
                                                       : 8'($urandom_range(0, 191));
                repeat ($urandom_range(0, 4))
                begin
                    col = 5'($urandom_range(0, CELLS - 1));
                    if ($urandom_range(0, 1) == 1)
                        send_transaction(OP_SCREEN,
                                         {row_pick[7:6], row_pick[2:0], row_pick[5:3], col},
                                         8'($urandom), 8'($urandom));
                    else
                        send_transaction(OP_SCREEN,
                                         ATTR_BASE + {3'b000, row_pick[7:6], row_pick[5:3],
                                                      col},
                                         8'($urandom), 8'($urandom));
                end
                send_transaction(OP_RENDER, 13'($urandom), 8'($urandom), row_pick);
            end
            else if (pick < 50)
                send_transaction(OP_SCREEN, 13'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 60)
            begin
                // palette entry write: select with a non-mode group, then data
                send_transaction(OP_SELECT, 13'($urandom),
                                 {($urandom_range(0, 2) == 0) ? 2'd0
                                  : 2'($urandom_range(2, 3)), 6'($urandom)},
                                 8'($urandom));
                send_transaction(OP_DATA, 13'($urandom), 8'($urandom), 8'($urandom));
            end
            else if (pick < 70)
            begin
                send_transaction(OP_SELECT, 13'($urandom), {GROUP_MODE, 6'($urandom)},
                                 8'($urandom));
                case ($urandom_range(0, 4))
                    0, 1:    send_transaction(OP_DATA, 13'($urandom), MODE_ON, 8'($urandom));
                    2, 3:    send_transaction(OP_DATA, 13'($urandom), MODE_OFF, 8'($urandom));
                    default: send_transaction(OP_DATA, 13'($urandom),
                                              8'($urandom_range(2, 255)), 8'($urandom));
                endcase
            end
            else if (pick < 80)
                send_transaction(OP_BORDER, 13'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 8))
                    send_transaction(OP_TICK, 13'($urandom), 8'($urandom), 8'($urandom));
            end
            else if (pick < 97)
                send_transaction(($urandom_range(0, 1) == 1) ? OP_SPARE_A : OP_SPARE_B,
                                 13'($urandom), 8'($urandom), 8'($urandom));
            else
                // half a ULAplus sequence on its own
                send_transaction(($urandom_range(0, 1) == 1) ? OP_SELECT : OP_DATA,
                                 13'($urandom), 8'($urandom), 8'($urandom));
        end

        start <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
